FILE: design/pwdt_pkg.sv
// ----------------------------------------------------------------------------
// pwdt_pkg
// Shared types and constants of the pointer warp delta tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package pwdt_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 18;
  localparam int DW         = 14;

  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STRAY_X  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STRAY_Y  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_X  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_Y  = 3'd5;

  localparam logic [14:0] STRAY_X_RESET = 15'd320;
  localparam logic [14:0] STRAY_Y_RESET = 15'd240;
  localparam logic [17:0] SCALE_RESET   = 18'd65536;

  typedef struct packed {
    logic signed [15:0] center_x;
    logic signed [15:0] center_y;
    logic [14:0]        stray_x;
    logic [14:0]        stray_y;
    logic [17:0]        scale_x;
    logic [17:0]        scale_y;
  } cfg_t;

endpackage

`default_nettype wire

FILE: design/pwdt_cfg.sv
// ----------------------------------------------------------------------------
// pwdt_cfg
// Configuration register file with write-only access.
// ----------------------------------------------------------------------------
`default_nettype none

module pwdt_cfg (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_we,
  input  wire logic [pwdt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [pwdt_pkg::CFG_DATA_W-1:0]  cfg_data,
  output pwdt_pkg::cfg_t                        cfg
);
  import pwdt_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.center_x <= '0;
      cfg.center_y <= '0;
      cfg.stray_x  <= STRAY_X_RESET;
      cfg.stray_y  <= STRAY_Y_RESET;
      cfg.scale_x  <= SCALE_RESET;
      cfg.scale_y  <= SCALE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CENTER_X: cfg.center_x <= cfg_data[15:0];
        REG_CENTER_Y: cfg.center_y <= cfg_data[15:0];
        REG_STRAY_X:  cfg.stray_x  <= cfg_data[14:0];
        REG_STRAY_Y:  cfg.stray_y  <= cfg_data[14:0];
        REG_SCALE_X:  cfg.scale_x  <= cfg_data[17:0];
        REG_SCALE_Y:  cfg.scale_y  <= cfg_data[17:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: design/pwdt_axis.sv
// ----------------------------------------------------------------------------
// pwdt_axis
// One axis: clamps the host delta, scales it and carries the remainder.
// ----------------------------------------------------------------------------
`default_nettype none

module pwdt_axis #(
  parameter int JUMP_LIMIT = 256
) (
  input  wire logic signed [16:0] diff,
  input  wire logic [17:0]        scale,
  input  wire logic signed [16:0] rem_in,
  output logic signed [11:0]      delta,
  output logic signed [16:0]      rem_out
);
  import pwdt_pkg::*;

  localparam logic signed [16:0] LIM     = 17'(JUMP_LIMIT);
  localparam logic signed [16:0] LIM_NEG = -17'(JUMP_LIMIT);

  logic signed [16:0]   diff_c;
  logic signed [DW-1:0] dc;
  logic signed [31:0]   dc_w;
  logic signed [31:0]   sc_w;
  logic signed [31:0]   prod;
  logic signed [31:0]   f;
  logic                 neg_frac;
  logic signed [15:0]   q;

  always_comb begin
    if (diff > LIM) begin
      diff_c = LIM;
    end else if (diff < LIM_NEG) begin
      diff_c = LIM_NEG;
    end else begin
      diff_c = diff;
    end
  end

  assign dc   = diff_c[DW-1:0];
  assign dc_w = 32'(dc);
  assign sc_w = {14'd0, scale};
  assign prod = dc_w * sc_w;
  assign f    = prod + {{15{rem_in[16]}}, rem_in};

  // Floor division by 65536 corrected to truncate toward zero.
  assign neg_frac = f[31] && (f[15:0] != 16'd0);
  assign q        = f[31:16] + {15'd0, neg_frac};
  assign rem_out  = {neg_frac, f[15:0]};

  always_comb begin
    if (q > 16'sd2047) begin
      delta = 12'sh7FF;
    end else if (q < -16'sd2048) begin
      delta = 12'sh800;
    end else begin
      delta = q[11:0];
    end
  end

endmodule

`default_nettype wire

FILE: design/pointer_warp_delta_tracker_core.sv
// ----------------------------------------------------------------------------
// pointer_warp_delta_tracker_core
// Turns absolute host pointer positions into relative emulated mouse motion.
// ----------------------------------------------------------------------------
// Path: a request is held in the input register, then its result in the result
// register. Throughput: one request per cycle unless the output stalls; the input
// register and the result register each hold one request, and the per-request
// state update is one combinational clamp and one multiply-add per axis.
// Reset: synchronous; clears tracking state and loads register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module pointer_warp_delta_tracker_core #(
  parameter int JUMP_LIMIT    = 256,
  parameter int WARP_LIFETIME = 2,
  parameter int GIVE_UP_COUNT = 3
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_we,
  input  wire logic [pwdt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [pwdt_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic                             req_type,
  input  wire logic signed [15:0]               host_x,
  input  wire logic signed [15:0]               host_y,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic signed [11:0]                    delta_x,
  output logic signed [11:0]                    delta_y,
  output logic [15:0]                           emu_pos_x,
  output logic [15:0]                           emu_pos_y,
  output logic                                  recenter_request
);
  import pwdt_pkg::*;

  localparam logic [1:0] LIFE    = 2'(WARP_LIFETIME);
  localparam logic [1:0] GIVE_UP = 2'(GIVE_UP_COUNT);

  function automatic logic [16:0] abs17(input logic signed [16:0] v);
    return v[16] ? 17'(-v) : v;
  endfunction

  cfg_t cfg;

  pwdt_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  logic               s1_valid;
  logic               s1_type;
  logic signed [15:0] s1_x;
  logic signed [15:0] s1_y;
  logic               advance;
  logic               step;

  logic signed [15:0] last_x, last_y, warp_x, warp_y;
  logic [1:0]         warp_ttl, warp_failures;
  logic signed [16:0] remainder_x, remainder_y;
  logic [15:0]        emu_x, emu_y;

  logic signed [15:0] last_x_next, last_y_next, warp_x_next, warp_y_next;
  logic [1:0]         warp_ttl_next, warp_failures_next;
  logic [1:0]         ttl_dec;
  logic signed [15:0] prev_x, prev_y;
  logic               req;
  logic [17:0]        dist_warp, dist_last;
  logic               stray;
  logic signed [16:0] diff_x, diff_y;
  logic signed [11:0] ax_delta, ay_delta;
  logic signed [16:0] ax_rem, ay_rem;
  logic [15:0]        emu_x_next, emu_y_next;

  assign advance  = !out_valid || !out_stall;
  assign in_stall = s1_valid && !advance;
  assign step     = s1_valid && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (advance || !s1_valid) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_type <= req_type;
      s1_x    <= host_x;
      s1_y    <= host_y;
    end
  end

  assign dist_warp = 18'(abs17({s1_x[15], s1_x} - {warp_x[15], warp_x}))
                   + 18'(abs17({s1_y[15], s1_y} - {warp_y[15], warp_y}));
  assign dist_last = 18'(abs17({s1_x[15], s1_x} - {last_x[15], last_x}))
                   + 18'(abs17({s1_y[15], s1_y} - {last_y[15], last_y}));
  assign stray = (abs17({s1_x[15], s1_x} - {cfg.center_x[15], cfg.center_x})
                  > {2'd0, cfg.stray_x})
              || (abs17({s1_y[15], s1_y} - {cfg.center_y[15], cfg.center_y})
                  > {2'd0, cfg.stray_y});
  assign ttl_dec = warp_ttl - 2'd1;

  always_comb begin
    last_x_next        = last_x;
    last_y_next        = last_y;
    warp_x_next        = warp_x;
    warp_y_next        = warp_y;
    warp_ttl_next      = warp_ttl;
    warp_failures_next = warp_failures;
    prev_x             = last_x;
    prev_y             = last_y;
    req                = 1'b0;
    if (!s1_type) begin
      warp_failures_next = 2'd0;
      last_x_next        = s1_x;
      last_y_next        = s1_y;
      warp_x_next        = cfg.center_x;
      warp_y_next        = cfg.center_y;
      warp_ttl_next      = LIFE;
      req                = 1'b1;
    end else begin
      if (warp_ttl != 2'd0) begin
        warp_ttl_next = ttl_dec;
        if (dist_warp <= dist_last) begin
          prev_x      = warp_x;
          prev_y      = warp_y;
          warp_x_next = s1_x;
          warp_y_next = s1_y;
          if (ttl_dec == 2'd0) begin
            last_x_next        = s1_x;
            last_y_next        = s1_y;
            warp_failures_next = 2'd0;
          end
        end else begin
          last_x_next   = s1_x;
          last_y_next   = s1_y;
          warp_ttl_next = 2'd0;
          if (warp_failures != 2'd3) begin
            warp_failures_next = warp_failures + 2'd1;
          end
        end
      end else begin
        last_x_next = s1_x;
        last_y_next = s1_y;
      end
      if ((warp_failures_next < GIVE_UP) && stray) begin
        last_x_next   = s1_x;
        last_y_next   = s1_y;
        warp_x_next   = cfg.center_x;
        warp_y_next   = cfg.center_y;
        warp_ttl_next = LIFE;
        req           = 1'b1;
      end
    end
  end

  assign diff_x = {s1_x[15], s1_x} - {prev_x[15], prev_x};
  assign diff_y = {s1_y[15], s1_y} - {prev_y[15], prev_y};

  pwdt_axis #(.JUMP_LIMIT(JUMP_LIMIT)) u_axis_x (
    .diff    (diff_x),
    .scale   (cfg.scale_x),
    .rem_in  (remainder_x),
    .delta   (ax_delta),
    .rem_out (ax_rem)
  );

  pwdt_axis #(.JUMP_LIMIT(JUMP_LIMIT)) u_axis_y (
    .diff    (diff_y),
    .scale   (cfg.scale_y),
    .rem_in  (remainder_y),
    .delta   (ay_delta),
    .rem_out (ay_rem)
  );

  assign emu_x_next = emu_x + {{4{ax_delta[11]}}, ax_delta};
  assign emu_y_next = emu_y - {{4{ay_delta[11]}}, ay_delta};

  always_ff @(posedge clk) begin
    if (rst) begin
      last_x        <= '0;
      last_y        <= '0;
      warp_x        <= '0;
      warp_y        <= '0;
      warp_ttl      <= '0;
      warp_failures <= '0;
      remainder_x   <= '0;
      remainder_y   <= '0;
      emu_x         <= '0;
      emu_y         <= '0;
    end else if (step) begin
      last_x        <= last_x_next;
      last_y        <= last_y_next;
      warp_x        <= warp_x_next;
      warp_y        <= warp_y_next;
      warp_ttl      <= warp_ttl_next;
      warp_failures <= warp_failures_next;
      if (s1_type) begin
        remainder_x <= ax_rem;
        remainder_y <= ay_rem;
        emu_x       <= emu_x_next;
        emu_y       <= emu_y_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      delta_x          <= s1_type ? ax_delta : 12'sd0;
      delta_y          <= s1_type ? ay_delta : 12'sd0;
      emu_pos_x        <= s1_type ? emu_x_next : emu_x;
      emu_pos_y        <= s1_type ? emu_y_next : emu_y;
      recenter_request <= req;
    end
  end

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid)
    else $error("input stalled with an empty input register");

  a_grab_result: assert property (@(posedge clk) disable iff (rst)
    (step && !s1_type) |=> (delta_x == 12'sd0 && delta_y == 12'sd0 && recenter_request))
    else $error("grab start result lacks zero deltas or recenter");

  a_ttl_bound: assert property (@(posedge clk) disable iff (rst)
    warp_ttl <= LIFE)
    else $error("warp lifetime counter beyond its start value");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    (advance && !s1_valid) |=> !out_valid)
    else $error("result register holds a request that was never loaded");

endmodule

`default_nettype wire

FILE: dv/pointer_warp_delta_tracker_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pointer_warp_delta_tracker_core_tb
// Self-checking bench for the pointer warp delta tracker core.
// A short table of directed requests covers the field extremes, grab starts,
// undone warps, giving up on recentering and the stray limits. Random pointer
// walks then run under several register settings, with random idle bursts on
// both handshakes. Every result is checked against pinned table values or a local tracker model.
// ----------------------------------------------------------------------------

module pointer_warp_delta_tracker_core_tb;

  import pwdt_pkg::*;

  localparam int MOVE_CLAMP = 256;
  localparam int WARP_LIFE = 2;
  localparam int GIVE_UP = 3;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 4;
  localparam int NUM_PHASES = 8;
  localparam int ITEMS_PER_PHASE = 240;
  localparam int NUM_PROBES = 19;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  typedef enum logic {GRAB_START = 1'b0, POINTER_MOVE = 1'b1} req_kind_e;

  typedef struct packed {
    logic signed [11:0] dx;
    logic signed [11:0] dy;
    logic [15:0]        ex;
    logic [15:0]        ey;
    logic               rc;
  } motion_t;

  typedef struct packed {
    logic    known;
    motion_t res;
  } pin_t;

  typedef struct packed {
    logic signed [16:0] frac;
    logic signed [11:0] step;
  } axis_t;

  typedef struct packed {
    req_kind_e          kind;
    logic signed [15:0] hx;
    logic signed [15:0] hy;
    logic               known;
    logic signed [11:0] dx;
    logic signed [11:0] dy;
    logic [15:0]        ex;
    logic [15:0]        ey;
    logic               rc;
  } probe_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic in_valid;
  logic in_stall;
  logic req_type;
  logic signed [15:0] host_x;
  logic signed [15:0] host_y;
  logic out_valid;
  logic out_stall;
  logic signed [11:0] delta_x;
  logic signed [11:0] delta_y;
  logic [15:0] emu_pos_x;
  logic [15:0] emu_pos_y;
  logic recenter_request;

  cfg_t regs;
  logic signed [15:0] seen_x, seen_y, aim_x, aim_y;
  logic [1:0] aim_life, miss_count;
  logic signed [16:0] frac_x, frac_y;
  logic [15:0] ctr_x, ctr_y;

  motion_t motion_q[$];
  pin_t pin_q[$];
  probe_t probe_tab [NUM_PROBES];

  int errors = 0;
  int cycles = 0;
  int n_items = 0;
  int n_grabs = 0;
  int n_results = 0;
  int n_recenters = 0;
  int n_settings = 0;
  int gap_pct = 0;
  int stall_pct = 0;
  int hold_cnt = 0;
  bit calm = 0;
  int cx = 0;
  int cy = 0;

  pointer_warp_delta_tracker_core #(
    .JUMP_LIMIT(MOVE_CLAMP),
    .WARP_LIFETIME(WARP_LIFE),
    .GIVE_UP_COUNT(GIVE_UP)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .req_type(req_type),
    .host_x(host_x),
    .host_y(host_y),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .delta_x(delta_x),
    .delta_y(delta_y),
    .emu_pos_x(emu_pos_x),
    .emu_pos_y(emu_pos_y),
    .recenter_request(recenter_request)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  function automatic int iabs(int v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic int clamp_jump(int v);
    if (v > MOVE_CLAMP) return MOVE_CLAMP;
    if (v < -MOVE_CLAMP) return -MOVE_CLAMP;
    return v;
  endfunction

  function automatic int spread(int m);
    return int'($urandom_range(0, 2 * m)) - m;
  endfunction

  // Scales one clamped delta and carries the signed fraction to the next request.
  function automatic axis_t scale_axis_step(int d, logic [17:0] k, logic signed [16:0] frac);
    longint f, q;
    axis_t r;
    f = longint'(d) * longint'(k) + longint'(frac);
    q = f / 65536;
    r.frac = 17'(f - q * 65536);
    if (q > 2047) q = 2047;
    else if (q < -2048) q = -2048;
    r.step = 12'(q);
    return r;
  endfunction

  function automatic void arm_warp();
    aim_x = regs.center_x;
    aim_y = regs.center_y;
    aim_life = 2'(WARP_LIFE);
  endfunction

  function automatic motion_t track_pointer(logic kind, logic signed [15:0] hx16,
                                            logic signed [15:0] hy16);
    int hx, hy, px, py, dw, dl;
    axis_t ax, ay;
    motion_t m;
    hx = hx16;
    hy = hy16;
    m = '0;
    if (kind == GRAB_START) begin
      miss_count = '0;
      seen_x = hx16;
      seen_y = hy16;
      arm_warp();
      m.rc = 1'b1;
    end else begin
      px = seen_x;
      py = seen_y;
      if (aim_life != 0) begin
        dw = iabs(hx - aim_x) + iabs(hy - aim_y);
        dl = iabs(hx - seen_x) + iabs(hy - seen_y);
        aim_life = aim_life - 2'd1;
        if (dw <= dl) begin
          px = aim_x;
          py = aim_y;
          aim_x = hx16;
          aim_y = hy16;
          if (aim_life == 0) begin
            seen_x = hx16;
            seen_y = hy16;
            miss_count = '0;
          end
        end else begin
          seen_x = hx16;
          seen_y = hy16;
          aim_life = '0;
          if (miss_count < 2'd3) miss_count = miss_count + 2'd1;
        end
      end else begin
        seen_x = hx16;
        seen_y = hy16;
      end
      ax = scale_axis_step(clamp_jump(hx - px), regs.scale_x, frac_x);
      ay = scale_axis_step(clamp_jump(hy - py), regs.scale_y, frac_y);
      frac_x = ax.frac;
      frac_y = ay.frac;
      m.dx = ax.step;
      m.dy = ay.step;
      ctr_x = ctr_x + 16'(int'(ax.step));
      ctr_y = ctr_y - 16'(int'(ay.step));
      if (int'(miss_count) < GIVE_UP) begin
        if (iabs(hx - int'($signed(regs.center_x))) > int'(regs.stray_x) ||
            iabs(hy - int'($signed(regs.center_y))) > int'(regs.stray_y)) begin
          seen_x = hx16;
          seen_y = hy16;
          arm_warp();
          m.rc = 1'b1;
        end
      end
    end
    m.ex = ctr_x;
    m.ey = ctr_y;
    return m;
  endfunction

  task automatic flag(string what, int got, int exp_v);
    errors++;
    if (errors <= 40) begin
      $display("MISMATCH at result %0d: %s got %0d, expected %0d", n_results, what, got, exp_v);
    end
  endtask

  always @(posedge clk) begin : watch
    motion_t want, guess;
    pin_t pin;
    if (rst) begin
      regs.center_x = '0;
      regs.center_y = '0;
      regs.stray_x = STRAY_X_RESET;
      regs.stray_y = STRAY_Y_RESET;
      regs.scale_x = SCALE_RESET;
      regs.scale_y = SCALE_RESET;
      seen_x = '0;
      seen_y = '0;
      aim_x = '0;
      aim_y = '0;
      aim_life = '0;
      miss_count = '0;
      frac_x = '0;
      frac_y = '0;
      ctr_x = '0;
      ctr_y = '0;
    end else begin
      if (out_valid && !out_stall) begin
        n_results++;
        if (motion_q.size() == 0) begin
          flag("result with no request pending", 1, 0);
        end else begin
          want = motion_q.pop_front();
          if (want.rc) n_recenters++;
          if (delta_x !== want.dx) flag("delta_x", int'(delta_x), int'(want.dx));
          if (delta_y !== want.dy) flag("delta_y", int'(delta_y), int'(want.dy));
          if (emu_pos_x !== want.ex) flag("emu_pos_x", int'(emu_pos_x), int'(want.ex));
          if (emu_pos_y !== want.ey) flag("emu_pos_y", int'(emu_pos_y), int'(want.ey));
          if (recenter_request !== want.rc) begin
            flag("recenter_request", int'(recenter_request), int'(want.rc));
          end
        end
      end
      if (in_valid && !in_stall) begin
        guess = track_pointer(req_type, host_x, host_y);
        pin = pin_q.pop_front();
        motion_q.push_back(pin.known ? pin.res : guess);
        n_items++;
        if (req_type == GRAB_START) n_grabs++;
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_CENTER_X: regs.center_x = cfg_data[15:0];
          REG_CENTER_Y: regs.center_y = cfg_data[15:0];
          REG_STRAY_X:  regs.stray_x = cfg_data[14:0];
          REG_STRAY_Y:  regs.stray_y = cfg_data[14:0];
          REG_SCALE_X:  regs.scale_x = cfg_data[17:0];
          REG_SCALE_Y:  regs.scale_y = cfg_data[17:0];
          default: ;
        endcase
      end
    end
  end

  always @(negedge clk) begin
    if (rst || calm) begin
      hold_cnt = 0;
      out_stall <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt--;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 99) < stall_pct) begin
      hold_cnt = $urandom_range(0, 18);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results still pending.", cycles, motion_q.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic send_request(req_kind_e kind, logic [15:0] hx, logic [15:0] hy, pin_t pin);
    if (!calm && $urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
    pin_q.push_back(pin);
    in_valid <= 1'b1;
    req_type <= kind;
    host_x <= hx;
    host_y <= hy;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
  endtask

  task automatic load_settings(int ph);
    logic [15:0] c_x, c_y;
    logic [14:0] s_x, s_y;
    logic [17:0] k_x, k_y;
    case (ph)
      0: begin
        c_x = 16'h8000;
        c_y = 16'h8000;
        s_x = '0;
        s_y = '0;
        k_x = '0;
        k_y = '0;
      end
      1: begin
        c_x = 16'h7fff;
        c_y = 16'h7fff;
        s_x = 15'h7fff;
        s_y = 15'h7fff;
        k_x = 18'h3ffff;
        k_y = 18'h3ffff;
      end
      2: begin
        c_x = '0;
        c_y = '0;
        s_x = STRAY_X_RESET;
        s_y = STRAY_Y_RESET;
        k_x = SCALE_RESET;
        k_y = SCALE_RESET;
      end
      default: begin
        c_x = 16'(spread(3000));
        c_y = 16'(spread(3000));
        s_x = 15'($urandom_range(4, 700));
        s_y = 15'($urandom_range(4, 700));
        k_x = ($urandom_range(0, 3) == 0) ? 18'($urandom) : 18'($urandom_range(20000, 140000));
        k_y = ($urandom_range(0, 3) == 0) ? 18'($urandom) : 18'($urandom_range(20000, 140000));
      end
    endcase
    in_valid <= 1'b0;
    while (motion_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    write_reg(REG_CENTER_X, {2'($urandom), c_x});
    write_reg(REG_CENTER_Y, {2'($urandom), c_y});
    write_reg(REG_STRAY_X, {3'($urandom), s_x});
    write_reg(REG_STRAY_Y, {3'($urandom), s_y});
    write_reg(REG_SCALE_X, k_x);
    write_reg(REG_SCALE_Y, k_y);
    write_reg(($urandom_range(0, 1) == 0) ? REG_SPARE_LO : REG_SPARE_HI, 18'($urandom));
    cfg_we <= 1'b0;
    cx = int'($signed(c_x));
    cy = int'($signed(c_y));
    n_settings++;
  endtask

  initial begin : stimulus
    int i, ph, r, reach, off_x, off_y;
    logic signed [15:0] hx, hy;
    req_kind_e kind;
    pin_t pin;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    req_type = 1'b0;
    host_x = '0;
    host_y = '0;
    out_stall = 1'b0;
    off_x = 0;
    off_y = 0;
    probe_tab = '{
      '{POINTER_MOVE, 0, 0, 1, 0, 0, 0, 0, 0},
      '{POINTER_MOVE, 10, -5, 1, 10, -5, 10, 5, 0},
      '{POINTER_MOVE, 32767, -32768, 1, 256, -256, 266, 261, 1},
      '{GRAB_START, -32768, 32767, 1, 0, 0, 266, 261, 1},
      '{POINTER_MOVE, 3, 4, 0, 0, 0, 0, 0, 0},
      '{POINTER_MOVE, 3, 5, 0, 0, 0, 0, 0, 0},
      '{POINTER_MOVE, 400, 0, 0, 0, 0, 0, 0, 0},
      '{POINTER_MOVE, 401, 0, 0, 0, 0, 0, 0, 0},
      '{POINTER_MOVE, 402, 0, 0, 0, 0, 0, 0, 0},
      '{POINTER_MOVE, 403, 0, 0, 0, 0, 0, 0, 0},
      '{POINTER_MOVE, -500, 300, 0, 0, 0, 0, 0, 0},
      '{GRAB_START, 10, 0, 0, 0, 0, 0, 0, 0},
      '{POINTER_MOVE, 5, 0, 0, 0, 0, 0, 0, 0},
      '{POINTER_MOVE, -321, 0, 0, 0, 0, 0, 0, 0},
      '{POINTER_MOVE, 0, 0, 0, 0, 0, 0, 0, 0},
      '{POINTER_MOVE, 320, -240, 0, 0, 0, 0, 0, 0},
      '{POINTER_MOVE, 320, 241, 0, 0, 0, 0, 0, 0},
      '{POINTER_MOVE, -1, -1, 0, 0, 0, 0, 0, 0},
      '{GRAB_START, 0, 0, 0, 0, 0, 0, 0, 0}
    };
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed requests run on the reset register values.
    n_settings = 1;
    gap_pct = 10;
    stall_pct = 10;
    for (i = 0; i < NUM_PROBES; i++) begin
      pin.known = probe_tab[i].known;
      pin.res = '{probe_tab[i].dx, probe_tab[i].dy, probe_tab[i].ex, probe_tab[i].ey,
                  probe_tab[i].rc};
      send_request(probe_tab[i].kind, probe_tab[i].hx, probe_tab[i].hy, pin);
    end

    // Random pointer walks around the window center. Most requests are small
    // moves or honored warps; a few are jumps, grab starts or pure noise.
    pin = '0;
    for (ph = 0; ph < NUM_PHASES; ph++) begin
      load_settings(ph);
      gap_pct = (ph % 3 == 0) ? 0 : ((ph % 3 == 1) ? 5 : 25);
      stall_pct = (ph % 3 == 1) ? 25 : ((ph % 3 == 2) ? 6 : 2);
      calm = (ph == NUM_PHASES - 1);
      for (i = 0; i < ITEMS_PER_PHASE; i++) begin
        r = $urandom_range(0, 99);
        kind = (r < 4) ? GRAB_START : POINTER_MOVE;
        if (r >= 4 && r < 9) begin
          hx = 16'($urandom);
          hy = 16'($urandom);
        end else begin
          if (r >= 9 && r < 30) begin
            off_x = spread(3);
            off_y = spread(3);
          end else if (r >= 30) begin
            reach = (r < 85) ? 40 : ((r < 97) ? 400 : 3000);
            off_x += spread(reach);
            off_y += spread(reach);
          end
          hx = 16'(cx + off_x);
          hy = 16'(cy + off_y);
        end
        off_x = int'(hx) - cx;
        off_y = int'(hy) - cy;
        send_request(kind, hx, hy, pin);
      end
    end

    in_valid <= 1'b0;
    while (motion_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES * 4) @(posedge clk);
    $display("Run covered %0d requests (%0d grab starts) over %0d register settings;",
             n_items, n_grabs, n_settings);
    $display("%0d results were checked, %0d of them with a recenter request.",
             n_results, n_recenters);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: filelist.f
design/pwdt_pkg.sv
design/pwdt_cfg.sv
design/pwdt_axis.sv
design/pointer_warp_delta_tracker_core.sv
dv/pointer_warp_delta_tracker_core_tb.sv
